// ----- rtl/hbwc_pkg.sv -----
// Shared constants, types and codes of the histogram bucket window counter.
package hbwc_pkg;

  localparam int BUCKETS   = 160;
  localparam int SLOT_W    = $clog2(BUCKETS);
  localparam int CNT_W     = 64;
  localparam int IDX_W     = 32;
  localparam int SH_IN_W   = 6;
  localparam int MAX_SHIFT = IDX_W - 1;
  localparam int SH_W      = $clog2(MAX_SHIFT + 1);

  typedef enum logic [1:0] {
    CMD_INC = 2'd0,
    CMD_GET = 2'd1,
    CMD_DS  = 2'd2,
    CMD_CLR = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMP,
    S_SPAN,
    S_RD,
    S_WR,
    S_DS_SETUP,
    S_DS_INIT,
    S_DS_RUN,
    S_DS_FLUSH
  } state_e;

  typedef struct packed {
    logic              clr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] raddr;
  } bank_req_t;

endpackage

// ----- rtl/histogram_bucket_window_counter.sv -----
// Top level: command sequencer, window registers and two ping-pong counter banks.
//
//  channel  | ports                                              | handshake
//  ---------+----------------------------------------------------+--------------------------
//  command  | cmd_i bucket_index_i amount_i shift_amount_i        | start_i high, busy_o low
//  result   | accepted_o bucket_value_o window_low_o             | done_o high for one cycle
//           | window_high_o is_empty_o                           |
//
// Increment and get step through compare, span check and counter read; an increment then
// finishes its read-modify-write through the single bank read port before the done_o
// strobe. A rejected increment or a get outside the window ends after the span check.
// Downscale walks the window one bucket a cycle through one 64-bit adder, merging
// into the idle bank, then swaps banks.
// Clear, an increment or get on an empty store and a no-op downscale end after the compare.
// Reset clears the valid bits at once; no clearing pass. The receiver cannot stall.
module histogram_bucket_window_counter
  import hbwc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              cmd_i,
  input  logic signed [IDX_W-1:0] bucket_index_i,
  input  logic [CNT_W-1:0]        amount_i,
  input  logic [SH_IN_W-1:0]      shift_amount_i,
  output logic                    done_o,
  output logic                    accepted_o,
  output logic [CNT_W-1:0]        bucket_value_o,
  output logic signed [IDX_W-1:0] window_low_o,
  output logic signed [IDX_W-1:0] window_high_o,
  output logic                    is_empty_o
);

  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] d);
    logic [IDX_W-1:0] w;
    w = d + IDX_W'(BUCKETS);
    return d[IDX_W-1] ? w[SLOT_W-1:0] : d[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(BUCKETS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  state_e state_q, state_d;

  // item payload
  cmd_e                    cmd_q;
  logic signed [IDX_W-1:0] idx_q;
  logic [CNT_W-1:0]        amt_q;
  logic [SH_W-1:0]         sh_q;

  // window state
  logic signed [IDX_W-1:0] low_q, low_d, high_q, high_d, anchor_q, anchor_d;
  logic                    empty_q, empty_d;
  logic                    sel_q, sel_d;

  // sequencer working registers
  logic                    gt_q, gt_d, lt_q, lt_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic signed [IDX_W-1:0] i_q, i_d;
  logic [SLOT_W-1:0]       src_q, src_d, dst_q, dst_d;
  logic signed [IDX_W-1:0] nlow_q, nlow_d, nhigh_q, nhigh_d, nbase_q, nbase_d;
  logic [IDX_W-1:0]        mask_q, mask_d;
  logic [CNT_W-1:0]        sum_q, sum_d;
  logic                    first_q, first_d;
  logic                    pv_q, pv_d, pend_q, pend_d;

  // result
  logic                    done_q, done_d;
  logic                    res_acc_q, res_acc_d;
  logic [CNT_W-1:0]        res_val_q, res_val_d;

  bank_req_t               req_act, req_oth, req0, req1;
  logic [CNT_W-1:0]        wdata, rd0, rd1, rd;

  logic [IDX_W:0]          span;
  logic [IDX_W-1:0]        i_next;
  logic [CNT_W-1:0]        merge_sum;
  logic                    accept;

  assign accept = start_i && (state_q == S_IDLE);

  assign span = gt_q ? ({idx_q[IDX_W-1], idx_q} - {low_q[IDX_W-1], low_q})
                     : ({high_q[IDX_W-1], high_q} - {idx_q[IDX_W-1], idx_q});
  assign i_next    = i_q + IDX_W'(1);
  assign merge_sum = (first_q ? '0 : sum_q) + rd;
  assign rd        = sel_q ? rd1 : rd0;

  always_comb begin
    state_d   = state_q;
    low_d     = low_q;
    high_d    = high_q;
    anchor_d  = anchor_q;
    empty_d   = empty_q;
    sel_d     = sel_q;
    gt_d      = gt_q;
    lt_d      = lt_q;
    slot_d    = slot_q;
    i_d       = i_q;
    src_d     = src_q;
    dst_d     = dst_q;
    nlow_d    = nlow_q;
    nhigh_d   = nhigh_q;
    nbase_d   = nbase_q;
    mask_d    = mask_q;
    sum_d     = sum_q;
    first_d   = first_q;
    pv_d      = pv_q;
    pend_d    = pend_q;
    done_d    = 1'b0;
    res_acc_d = res_acc_q;
    res_val_d = res_val_q;
    wdata     = amt_q;
    req_act   = '0;
    req_oth   = '0;
    req_act.raddr = (state_q == S_DS_RUN) ? src_q : slot_q;
    req_oth.raddr = req_act.raddr;

    // merge the bucket whose data returns this cycle
    if (((state_q == S_DS_RUN) || (state_q == S_DS_FLUSH)) && pv_q) begin
      if (pend_q) begin
        req_oth.we    = 1'b1;
        req_oth.waddr = dst_q;
        wdata         = merge_sum;
        dst_d         = slot_inc(dst_q);
        first_d       = 1'b1;
      end else begin
        sum_d   = merge_sum;
        first_d = 1'b0;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        gt_d = idx_q > high_q;
        lt_d = idx_q < low_q;
        state_d = S_IDLE;
        done_d    = 1'b1;
        res_acc_d = 1'b1;
        res_val_d = '0;
        unique case (cmd_q)
          CMD_INC: begin
            if (empty_q) begin
              // anchor the window at this index, counter slot zero
              low_d         = idx_q;
              high_d        = idx_q;
              anchor_d      = idx_q;
              empty_d       = 1'b0;
              req_act.we    = 1'b1;
              req_act.waddr = '0;
            end else begin
              state_d = S_SPAN;
              done_d  = 1'b0;
            end
          end
          CMD_GET: begin
            if (!empty_q) begin
              state_d = S_SPAN;
              done_d  = 1'b0;
            end
          end
          CMD_DS: begin
            if (!empty_q && (sh_q != '0)) begin
              state_d = S_DS_SETUP;
              done_d  = 1'b0;
            end
          end
          CMD_CLR: begin
            req_act.clr = 1'b1;
            req_oth.clr = 1'b1;
            low_d       = '0;
            high_d      = '0;
            anchor_d    = '0;
            empty_d     = 1'b1;
          end
          default: ;
        endcase
      end
      S_SPAN: begin
        slot_d = slot_of(idx_q - anchor_q);
        if (cmd_q == CMD_INC) begin
          if ((gt_q || lt_q) && (span >= (IDX_W + 1)'(BUCKETS))) begin
            // window would grow too wide: drop the item
            state_d   = S_IDLE;
            done_d    = 1'b1;
            res_acc_d = 1'b0;
            res_val_d = '0;
          end else begin
            if (gt_q) high_d = idx_q;
            if (lt_q) low_d  = idx_q;
            state_d = S_RD;
          end
        end else if (gt_q || lt_q) begin
          state_d   = S_IDLE;
          done_d    = 1'b1;
          res_acc_d = 1'b1;
          res_val_d = '0;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        state_d   = S_IDLE;
        done_d    = 1'b1;
        res_acc_d = 1'b1;
        if (cmd_q == CMD_INC) begin
          req_act.we    = 1'b1;
          req_act.waddr = slot_q;
          wdata         = rd + amt_q;
          res_val_d     = '0;
        end else begin
          res_val_d = rd;
        end
      end
      S_DS_SETUP: begin
        nlow_d      = low_q >>> sh_q;
        nhigh_d     = high_q >>> sh_q;
        nbase_d     = anchor_q >>> sh_q;
        mask_d      = (IDX_W'(1) << sh_q) - IDX_W'(1);
        src_d       = slot_of(low_q - anchor_q);
        i_d         = low_q;
        req_oth.clr = 1'b1;
        pv_d        = 1'b0;
        first_d     = 1'b1;
        state_d     = S_DS_INIT;
      end
      S_DS_INIT: begin
        dst_d   = slot_of(nlow_q - nbase_q);
        state_d = S_DS_RUN;
      end
      S_DS_RUN: begin
        // issue the read of bucket i; its group ends when i+1 starts a new one or i is the top
        pv_d   = 1'b1;
        pend_d = ((i_next & mask_q) == '0) || (i_q == high_q);
        i_d    = i_next;
        src_d  = slot_inc(src_q);
        if (i_q == high_q) begin
          state_d = S_DS_FLUSH;
        end
      end
      S_DS_FLUSH: begin
        pv_d      = 1'b0;
        sel_d     = !sel_q;
        low_d     = nlow_q;
        high_d    = nhigh_q;
        anchor_d  = nbase_q;
        state_d   = S_IDLE;
        done_d    = 1'b1;
        res_acc_d = 1'b1;
        res_val_d = '0;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign req0 = sel_q ? req_oth : req_act;
  assign req1 = sel_q ? req_act : req_oth;

  hbwc_bank u_bank0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req0),
    .wdata_i (wdata),
    .rdata_o (rd0)
  );

  hbwc_bank u_bank1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req1),
    .wdata_i (wdata),
    .rdata_o (rd1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      low_q    <= '0;
      high_q   <= '0;
      anchor_q <= '0;
      empty_q  <= 1'b1;
      sel_q    <= 1'b0;
      pv_q     <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      low_q    <= low_d;
      high_q   <= high_d;
      anchor_q <= anchor_d;
      empty_q  <= empty_d;
      sel_q    <= sel_d;
      pv_q     <= pv_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(cmd_i);
      idx_q <= bucket_index_i;
      amt_q <= amount_i;
      sh_q  <= (shift_amount_i > SH_IN_W'(MAX_SHIFT)) ? SH_W'(MAX_SHIFT)
                                                      : shift_amount_i[SH_W-1:0];
    end
    gt_q      <= gt_d;
    lt_q      <= lt_d;
    slot_q    <= slot_d;
    i_q       <= i_d;
    src_q     <= src_d;
    dst_q     <= dst_d;
    nlow_q    <= nlow_d;
    nhigh_q   <= nhigh_d;
    nbase_q   <= nbase_d;
    mask_q    <= mask_d;
    sum_q     <= sum_d;
    first_q   <= first_d;
    pend_q    <= pend_d;
    res_acc_q <= res_acc_d;
    res_val_q <= res_val_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign accepted_o     = res_acc_q;
  assign bucket_value_o = res_val_q;
  assign window_low_o   = low_q;
  assign window_high_o  = high_q;
  assign is_empty_o     = empty_q;

endmodule

// ----- rtl/hbwc_bank.sv -----
// One counter bank: memory with registered read and per-entry valid bits.
module hbwc_bank
  import hbwc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bank_req_t        req_i,
  input  logic [CNT_W-1:0] wdata_i,
  output logic [CNT_W-1:0] rdata_o
);

  logic [CNT_W-1:0]   mem [BUCKETS];
  logic [BUCKETS-1:0] valid_q;
  logic [CNT_W-1:0]   rd_q;
  logic               rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= wdata_i;
    end
    rd_q <= mem[req_i.raddr];
  end

  // an entry that was never written since the last clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      rd_valid_q <= valid_q[req_i.raddr];
    end
  end

  assign rdata_o = rd_valid_q ? rd_q : '0;

endmodule

// ----- verif/tb_histogram_bucket_window_counter.sv -----
// Self-checking testbench for the histogram bucket window counter.
module tb_histogram_bucket_window_counter;
  import hbwc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_MIN   = 32'sh8000_0000;
  localparam int IDX_MAX   = 32'sh7fff_ffff;
  localparam int LIMIT     = 1_000_000;
  localparam logic [CNT_W-1:0] AMT_MAX = '1;
  localparam logic [CNT_W-1:0] AMT_TOP = {1'b1, {(CNT_W-1){1'b0}}};

  typedef struct packed {
    logic                    accepted;
    logic [CNT_W-1:0]        value;
    logic signed [IDX_W-1:0] lo;
    logic signed [IDX_W-1:0] hi;
    logic                    empty;
  } window_report_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic                    busy_o;
  logic [1:0]              cmd_i = CMD_GET;
  logic signed [IDX_W-1:0] bucket_index_i = '0;
  logic [CNT_W-1:0]        amount_i = '0;
  logic [SH_IN_W-1:0]      shift_amount_i = '0;
  logic                    done_o;
  logic                    accepted_o;
  logic [CNT_W-1:0]        bucket_value_o;
  logic signed [IDX_W-1:0] window_low_o;
  logic signed [IDX_W-1:0] window_high_o;
  logic                    is_empty_o;

  // Shadow copy of the counter store and window registers
  logic [CNT_W-1:0] tally [BUCKETS];
  int               win_lo;
  int               win_hi;
  int               win_anchor;
  logic             win_empty;

  window_report_t window_reports[$];
  int             mismatches = 0;
  int             cycles = 0;
  int             idle_pct = 0;

  histogram_bucket_window_counter dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .cmd_i,
    .bucket_index_i,
    .amount_i,
    .shift_amount_i,
    .done_o,
    .accepted_o,
    .bucket_value_o,
    .window_low_o,
    .window_high_o,
    .is_empty_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               window_reports.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void wipe_histogram();
    foreach (tally[k]) tally[k] = '0;
    win_lo     = 0;
    win_hi     = 0;
    win_anchor = 0;
    win_empty  = 1'b1;
  endfunction

  // Circular position of a bucket relative to the anchor
  function automatic int slot_for(longint idx, longint base);
    longint d;
    d = idx - base;
    if (d < 0) d += BUCKETS;
    if (d < 0 || d >= BUCKETS) return 0;
    return int'(d);
  endfunction

  function automatic window_report_t advance_histogram(cmd_e cmd, int idx,
                                                       logic [CNT_W-1:0] amt,
                                                       logic [SH_IN_W-1:0] sh);
    window_report_t   rep;
    logic [CNT_W-1:0] merged [BUCKETS];
    longint           i;
    longint           base;
    int               s;
    rep.accepted = 1'b1;
    rep.value    = '0;
    case (cmd)
      CMD_INC: begin
        if (win_empty) begin
          win_lo     = idx;
          win_hi     = idx;
          win_anchor = idx;
          win_empty  = 1'b0;
          tally[0]   = tally[0] + amt;
        end else if (idx > win_hi && longint'(idx) - longint'(win_lo) + 1 > BUCKETS) begin
          rep.accepted = 1'b0;
        end else if (idx < win_lo && longint'(win_hi) - longint'(idx) + 1 > BUCKETS) begin
          rep.accepted = 1'b0;
        end else begin
          if (idx > win_hi) win_hi = idx;
          if (idx < win_lo) win_lo = idx;
          tally[slot_for(idx, win_anchor)] = tally[slot_for(idx, win_anchor)] + amt;
        end
      end
      CMD_GET: begin
        if (!win_empty && idx >= win_lo && idx <= win_hi)
          rep.value = tally[slot_for(idx, win_anchor)];
      end
      CMD_DS: begin
        s = (sh > MAX_SHIFT) ? MAX_SHIFT : int'(sh);
        if (s != 0 && !win_empty) begin
          base = longint'(win_anchor) >>> s;
          foreach (merged[k]) merged[k] = '0;
          // fold every occupied bucket into its floored parent
          for (i = win_lo; i <= win_hi; i++)
            merged[slot_for(i >>> s, base)] = merged[slot_for(i >>> s, base)] +
                                              tally[slot_for(i, win_anchor)];
          tally      = merged;
          win_lo     = int'(longint'(win_lo) >>> s);
          win_hi     = int'(longint'(win_hi) >>> s);
          win_anchor = int'(base);
        end
      end
      default: wipe_histogram();
    endcase
    rep.lo    = win_lo;
    rep.hi    = win_hi;
    rep.empty = win_empty;
    return rep;
  endfunction

  // Hold start until the block takes the item, then record what it must report
  task automatic send_item(cmd_e cmd, int idx, logic [CNT_W-1:0] amt,
                           logic [SH_IN_W-1:0] sh);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    cmd_i          <= cmd;
    bucket_index_i <= idx;
    amount_i       <= amt;
    shift_amount_i <= sh;
    do @(posedge clk_i); while (busy_o);
    window_reports.push_back(advance_histogram(cmd, idx, amt, sh));
  endtask

  function automatic logic [CNT_W-1:0] rand_amount();
    case ($urandom_range(9))
      0, 1, 2, 3: return CNT_W'($urandom_range(1000));
      4, 5, 6:    return {$urandom, $urandom};
      default:    return AMT_MAX - CNT_W'($urandom_range(1000));
    endcase
  endfunction

  function automatic int pick_center();
    case ($urandom_range(9))
      6, 7:    return $urandom;
      8:       return IDX_MAX - int'($urandom_range(200));
      9:       return IDX_MIN + int'($urandom_range(200));
      default: return int'($urandom_range(600)) - 300;
    endcase
  endfunction

  task automatic test_empty_store();
    send_item(CMD_GET, 0, rand_amount(), 6'd3);
    send_item(CMD_DS, 0, rand_amount(), 6'd5);
    send_item(CMD_CLR, IDX_MIN, AMT_MAX, 6'd63);
  endtask

  task automatic test_window_edges();
    send_item(CMD_INC, IDX_MAX, AMT_MAX, 6'd0);
    send_item(CMD_INC, IDX_MAX - 159, 64'd7, 6'd0);
    send_item(CMD_INC, IDX_MAX - 160, 64'd9, 6'd0);
    // wrap the top counter back to zero
    send_item(CMD_INC, IDX_MAX, 64'd1, 6'd0);
    send_item(CMD_GET, IDX_MAX, '0, 6'd0);
    send_item(CMD_GET, IDX_MAX - 160, '0, 6'd0);
    send_item(CMD_CLR, 0, '0, 6'd0);
    send_item(CMD_INC, IDX_MIN, AMT_TOP, 6'd0);
    send_item(CMD_INC, IDX_MIN + 160, 64'd5, 6'd0);
    send_item(CMD_GET, IDX_MIN + 5, '0, 6'd0);
  endtask

  task automatic test_downscale();
    send_item(CMD_DS, 0, '0, 6'd40);
    send_item(CMD_GET, -1, '0, 6'd0);
    send_item(CMD_CLR, 0, '0, 6'd0);
    send_item(CMD_INC, -5, 64'd3, 6'd0);
    send_item(CMD_INC, 7, AMT_TOP, 6'd0);
    send_item(CMD_INC, 6, AMT_TOP, 6'd0);
    send_item(CMD_DS, 0, '0, 6'd0);
    // 6 and 7 merge into 3 and overflow
    send_item(CMD_DS, 0, '0, 6'd1);
    send_item(CMD_GET, 3, '0, 6'd0);
    send_item(CMD_DS, 0, '0, 6'd63);
    send_item(CMD_GET, -1, '0, 6'd0);
    send_item(CMD_CLR, 0, '0, 6'd0);
  endtask

  task automatic run_random_phase(int count, int pct);
    int               n;
    int               k;
    int               center;
    int               idx;
    int               s;
    logic [CNT_W-1:0] amt;
    logic [5:0]       sh;
    cmd_e             cmd;
    idle_pct = pct;
    center   = pick_center();
    for (n = 0; n < count; n++) begin
      k   = $urandom_range(99);
      amt = rand_amount();
      sh  = 6'($urandom_range(63));
      idx = center + int'($urandom_range(200)) - 100;
      if (k < 52) begin
        cmd = CMD_INC;
        if ($urandom_range(19) == 0) idx = $urandom;
      end else if (k < 78) begin
        cmd = CMD_GET;
        idx = center + int'($urandom_range(240)) - 120;
        if ($urandom_range(19) == 0) idx = $urandom;
      end else if (k < 90) begin
        cmd = CMD_DS;
        if ($urandom_range(4) != 0) sh = 6'($urandom_range(3, 1));
        s = (sh > MAX_SHIFT) ? MAX_SHIFT : int'(sh);
        // follow the window as it shrinks
        center = center >>> s;
      end else if (k < 94) begin
        cmd    = CMD_CLR;
        center = pick_center();
      end else begin
        cmd = cmd_e'($urandom_range(3));
        idx = $urandom;
      end
      send_item(cmd, idx, amt, sh);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    window_report_t want;
    window_report_t got;
    if (rst_ni && done_o) begin
      got = '{accepted_o, bucket_value_o, window_low_o, window_high_o, is_empty_o};
      if (window_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result at cycle %0d: acc=%0b val=%h lo=%0d hi=%0d empty=%0b",
                   cycles, got.accepted, got.value, got.lo, got.hi, got.empty);
      end else begin
        want = window_reports.pop_front();
        if (got.accepted !== want.accepted || got.value !== want.value ||
            got.lo !== want.lo || got.hi !== want.hi || got.empty !== want.empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at cycle %0d: exp acc=%0b val=%h lo=%0d hi=%0d empty=%0b",
                      " got acc=%0b val=%h lo=%0d hi=%0d empty=%0b"}, cycles,
                     want.accepted, want.value, want.lo, want.hi, want.empty,
                     got.accepted, got.value, got.lo, got.hi, got.empty);
        end
      end
    end
  end

  initial begin
    wipe_histogram();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_store();
    test_window_edges();
    test_downscale();
    run_random_phase(320, 0);
    run_random_phase(320, 68);
    run_random_phase(310, 32);
    start_i <= 1'b0;
    while (window_reports.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/hbwc_pkg.sv
rtl/hbwc_bank.sv
rtl/histogram_bucket_window_counter.sv
verif/tb_histogram_bucket_window_counter.sv
